// ----- hw/rtl/cmed_pkg.sv -----
// Shared types and constants for the column median block.
// Used by cmed_cell and column_median; depends on nothing else.
`default_nettype none

package cmed_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COL_W    = 4;
    localparam int MEDIAN_W = 33;
    localparam int ECOUNT_W = 7;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;

    // register index as seen in paddr[2]
    localparam logic REG_SELECTED_COLUMN = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // command broadcast to every cell of the sorting chain
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cmed_cell.sv -----
// One cell of the insertion-sort chain: holds one kept word.
// Depends on cmed_pkg.
`default_nettype none

module cmed_cell (
    input  wire                       clk,
    input  wire cmed_pkg::cell_ctrl_t ctrl,
    input  wire cmed_pkg::sample_t    new_value,
    input  wire                       occupied,
    input  wire cmed_pkg::sample_t    left_value,
    input  wire                       left_gt,
    input  wire cmed_pkg::sample_t    right_value,
    output cmed_pkg::sample_t         value,
    output logic                      gt
);
    import cmed_pkg::*;

    sample_t value_reg;
    sample_t value_next;

    // empty cells count as larger so the new word lands at the end
    assign gt    = !occupied || (value_reg > new_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert && gt)
        begin
            value_next = left_gt ? left_value : new_value;
        end
        else if (ctrl.drain)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/column_median.sv -----
// Top level of the column median block: APB register, control, cell chain.
// Depends on cmed_pkg and cmed_cell.
`default_nettype none

// Words of the selected column are placed in sorted order by a chain of
// MAX_ROWS cells, one word per clock while idle: busy stays low and start
// may be held high every cycle. A word with last_of_matrix set is placed
// too and then the chain is shifted toward cell 0 until the upper middle
// word has passed, with busy high; result_valid pulses in ST_EMIT, the last
// busy state, and the result cannot be held off.
// median_doubled is the sum of the two middle words (twice the middle word
// for an odd count), i.e. the median in Q16.16 with one extra fraction bit.
module column_median #(
    parameter int MAX_ROWS  = 64,
    parameter int ROW_WIDTH = 10
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [cmed_pkg::ADDR_W-1:0]      paddr,
    input  wire  [cmed_pkg::APB_W-1:0]       pwdata,
    output logic [cmed_pkg::APB_W-1:0]       prdata,
    output logic                             pready,
    // input words
    input  wire                              start,
    output logic                             busy,
    input  wire  signed [cmed_pkg::SAMPLE_W-1:0] sample,
    input  wire  [cmed_pkg::COL_W-1:0]       column_number,
    input  wire                              last_of_matrix,
    // results
    output logic                             result_valid,
    output logic signed [cmed_pkg::MEDIAN_W-1:0] median_doubled,
    output logic [cmed_pkg::ECOUNT_W-1:0]    element_count,
    output logic                             empty_set,
    output logic                             overflowed
);
    import cmed_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    logic [COL_W-1:0] sel_col_reg;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic             ovf_reg,     ovf_next;
    logic [CNT_W-1:0] k_reg,       k_next;
    sample_t          lo_reg,      lo_next;
    sample_t          hi_reg,      hi_next;
    state_t           state_reg,   state_next;

    cell_ctrl_t       ctrl;
    logic             accept;
    logic             match;
    logic             has_room;
    logic [CNT_W-1:0] lo_idx;
    logic [CNT_W-1:0] hi_idx;
    logic             cfg_write;

    sample_t          cell_value [MAX_ROWS];
    logic             cell_gt    [MAX_ROWS];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_col_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == REG_SELECTED_COLUMN))
        begin
            sel_col_reg <= pwdata[COL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_SELECTED_COLUMN)
        begin
            prdata = {{(APB_W-COL_W){1'b0}}, sel_col_reg};
        end
    end

    // ---------------- control ----------------
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign match    = (column_number == sel_col_reg)
                      && (32'(column_number) < ROW_WIDTH);
    assign has_room = (count_reg < CNT_W'(MAX_ROWS));
    assign lo_idx   = (count_reg - CNT_W'(1)) >> 1;
    assign hi_idx   = count_reg >> 1;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        k_next      = k_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ctrl.insert = 1'b0;
        ctrl.drain  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (match && has_room)
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    else if (match)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_of_matrix)
                    begin
                        k_next = '0;
                        if (count_next == '0)
                        begin
                            lo_next    = '0;
                            hi_next    = '0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                // cell 0 holds the sorted word of rank k
                ctrl.drain = 1'b1;
                k_next     = k_reg + CNT_W'(1);
                if (k_reg == lo_idx)
                begin
                    lo_next = cell_value[0];
                end
                if (k_reg == hi_idx)
                begin
                    hi_next    = cell_value[0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    // ---------------- result ----------------
    assign result_valid   = (state_reg == ST_EMIT);
    assign median_doubled = {lo_reg[SAMPLE_W-1], lo_reg} + {hi_reg[SAMPLE_W-1], hi_reg};
    assign element_count  = ECOUNT_W'(count_reg);
    assign empty_set      = (count_reg == '0);
    assign overflowed     = ovf_reg;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < MAX_ROWS; i++)
    begin : g_cell
        sample_t left_v;
        logic    left_g;
        sample_t right_v;
        logic    occ;

        assign occ = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_v = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_inner
            assign left_v = cell_value[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == MAX_ROWS - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid
            assign right_v = cell_value[i+1];
        end

        cmed_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .new_value   (sample),
            .occupied    (occ),
            .left_value  (left_v),
            .left_gt     (left_g),
            .right_value (right_v),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );
    end

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ROWS))
        else $error("kept count above capacity");

    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_of_matrix |=> busy)
        else $error("last word did not start result phase");

    a_cleared_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> (count_reg == '0) && !ovf_reg && !busy)
        else $error("collection not cleared after result");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && empty_set |-> median_doubled == '0)
        else $error("empty set with nonzero median");

endmodule

`default_nettype wire

// ----- bench/column_median_tb.sv -----
// Self-checking bench for column_median: directed table, then random matrices.
// Needs cmed_pkg and column_median; expected medians come from typed table rows or
// a sorted-queue predictor kept in step with every accepted word and register write.

module column_median_tb;

    import cmed_pkg::*;

    localparam int MAX_ROWS   = 64;
    localparam int ROW_WIDTH  = 10;
    localparam int NUM_WORDS  = 800;
    localparam int STALL_MAX  = 18;
    localparam int QUIET_MAX  = 2000;
    localparam int NO_CONFIG  = -1;

    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median;
        logic [ECOUNT_W-1:0]        count;
        logic                       empty;
        logic                       ovf;
    } median_t;

    typedef struct packed {
        int          set_col;   // register write before the word, NO_CONFIG for none
        sample_t     smp;
        logic [3:0]  col;
        logic        last;
        bit          typed;
        median_t     res;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [APB_W-1:0]    pwdata = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;
    logic                start = 1'b0;
    logic                busy;
    sample_t             sample = '0;
    logic [COL_W-1:0]    column_number = '0;
    logic                last_of_matrix = 1'b0;
    logic                result_valid;
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic [ECOUNT_W-1:0] element_count;
    logic                empty_set;
    logic                overflowed;

    // typed expectation travels with the word it belongs to
    bit                  typed_on = 1'b0;
    median_t             typed_res = '0;

    // predictor state
    sample_t             col_values[$];
    bit                  dropped_any = 1'b0;
    logic [3:0]          model_col = '0;

    median_t             medians_due[$];
    int                  mismatch_count = 0;
    int                  quiet_cycles = 0;
    logic [3:0]          drive_col = '0;

    column_median #(
        .MAX_ROWS  (MAX_ROWS),
        .ROW_WIDTH (ROW_WIDTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .sample         (sample),
        .column_number  (column_number),
        .last_of_matrix (last_of_matrix),
        .result_valid   (result_valid),
        .median_doubled (median_doubled),
        .element_count  (element_count),
        .empty_set      (empty_set),
        .overflowed     (overflowed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Sorted insert of one word; returns 1 with the median when the word closes a matrix.
    function automatic bit sort_and_median(input sample_t s, input logic [3:0] c,
                                           input logic l, output median_t r);
        int pos;
        int n;
        sample_t lo;
        sample_t hi;
        r = '0;
        if (c == model_col && c < ROW_WIDTH)
        begin
            if (col_values.size() < MAX_ROWS)
            begin
                pos = col_values.size();
                while (pos > 0 && col_values[pos-1] > s)
                    pos--;
                col_values.insert(pos, s);
            end
            else
                dropped_any = 1'b1;
        end
        if (!l)
            return 1'b0;
        n = col_values.size();
        if (n > 0)
        begin
            hi = col_values[n/2];
            lo = (n % 2 == 1) ? hi : col_values[n/2-1];
            r.median = MEDIAN_W'(lo) + MEDIAN_W'(hi);
        end
        r.count = ECOUNT_W'(n);
        r.empty = (n == 0);
        r.ovf   = dropped_any;
        col_values.delete();
        dropped_any = 1'b0;
        return 1'b1;
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 4))
            0: return sample_t'(($urandom_range(0, 7) - 4) << 16);   // few distinct, many ties
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return sample_t'($urandom());
        endcase
    endfunction

    task automatic drive_word(input sample_t s, input logic [3:0] c, input logic l,
                              input int gap, input bit t, input median_t e);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        sample         <= s;
        column_number  <= c;
        last_of_matrix <= l;
        typed_on       <= t;
        typed_res      <= e;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every median has come out and the chain is quiet
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (medians_due.size() != 0 || busy)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_column(input logic [3:0] c);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_SELECTED_COLUMN, 2'b00};
        pwdata  <= ($urandom() & ~32'hF) | APB_W'(c);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        drive_col = c;
    endtask

    always @(posedge clk)
    begin : monitor
        bit      progress;
        median_t want;
        median_t got;
        progress = 1'b0;
        if (rst_n)
        begin
            if (result_valid)
            begin
                progress = 1'b1;
                if (medians_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, median_doubled %h count %0d",
                             $time, median_doubled, element_count);
                end
                else
                begin
                    want = medians_due.pop_front();
                    if (median_doubled !== want.median)
                    begin
                        mismatch_count++;
                        $display("%0t: median_doubled expected %h, got %h",
                                 $time, want.median, median_doubled);
                    end
                    if (element_count !== want.count)
                    begin
                        mismatch_count++;
                        $display("%0t: element_count expected %0d, got %0d",
                                 $time, want.count, element_count);
                    end
                    if (empty_set !== want.empty)
                    begin
                        mismatch_count++;
                        $display("%0t: empty_set expected %b, got %b",
                                 $time, want.empty, empty_set);
                    end
                    if (overflowed !== want.ovf)
                    begin
                        mismatch_count++;
                        $display("%0t: overflowed expected %b, got %b",
                                 $time, want.ovf, overflowed);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                progress = 1'b1;
                if (paddr[2] == REG_SELECTED_COLUMN)
                    model_col = pwdata[3:0];
            end
            if (start && !busy)
            begin
                progress = 1'b1;
                if (sort_and_median(sample, column_number, last_of_matrix, got))
                    medians_due.push_back(typed_on ? typed_res : got);
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    dir_row_t dir_rows [0:20] = '{
        // empty matrix straight after reset
        '{NO_CONFIG, 32'h0000_0000, 4'd3, 1'b1, 1'b1, '{33'h0_0000_0000, 7'd0, 1'b1, 1'b0}},
        '{NO_CONFIG, 32'h7FFF_FFFF, 4'd0, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h7FFF_FFFF, 4'd0, 1'b1, 1'b1, '{33'h0_FFFF_FFFE, 7'd2, 1'b0, 1'b0}},
        '{NO_CONFIG, 32'h8000_0000, 4'd0, 1'b1, 1'b1, '{33'h1_0000_0000, 7'd1, 1'b0, 1'b0}},
        '{NO_CONFIG, 32'h7FFF_FFFF, 4'd0, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h8000_0000, 4'd0, 1'b1, 1'b1, '{33'h1_FFFF_FFFF, 7'd2, 1'b0, 1'b0}},
        // odd count, unsorted arrival, a foreign column in between
        '{NO_CONFIG, 32'h0005_8000, 4'd0, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'hFFFE_C000, 4'd0, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h1234_5678, 4'd1, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h0003_0000, 4'd0, 1'b1, 1'b0, '0},
        // ties
        '{NO_CONFIG, 32'h0001_0000, 4'd0, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h0001_0000, 4'd0, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h0002_0000, 4'd0, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h0001_0000, 4'd0, 1'b1, 1'b0, '0},
        // top valid column, plus a column outside the matrix
        '{9,         32'hFFFF_FFFF, 4'd9, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h0000_0000, 4'd15, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h0000_0001, 4'd9, 1'b1, 1'b0, '0},
        // selected column outside the matrix keeps nothing
        '{15,        32'h7FFF_FFFF, 4'd15, 1'b0, 1'b0, '0},
        '{NO_CONFIG, 32'h0000_0000, 4'd15, 1'b1, 1'b1, '{33'h0_0000_0000, 7'd0, 1'b1, 1'b0}},
        '{10,        32'h5555_5555, 4'd10, 1'b1, 1'b1, '{33'h0_0000_0000, 7'd0, 1'b1, 1'b0}},
        '{5,         32'hAAAA_AAAA, 4'd5, 1'b1, 1'b0, '0}
    };

    initial
    begin
        int         words_sent;
        int         len;
        int         kind;
        int         k;
        bit         burst;
        logic [3:0] c;
        words_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].set_col != NO_CONFIG)
            begin
                wait_drained();
                write_column(dir_rows[i].set_col[3:0]);
            end
            drive_word(dir_rows[i].smp, dir_rows[i].col, dir_rows[i].last,
                       $urandom_range(0, STALL_MAX), dir_rows[i].typed, dir_rows[i].res);
        end

        while (words_sent < NUM_WORDS)
        begin
            if (words_sent == 0 || $urandom_range(0, 5) == 0)
            begin
                wait_drained();
                case ($urandom_range(0, 4))
                    0: write_column(4'd0);
                    1: write_column(4'd9);
                    2: write_column(4'($urandom_range(10, 15)));
                    default: write_column(4'($urandom_range(0, 9)));
                endcase
            end
            else if ($urandom_range(0, 7) == 0)
                wait_drained();

            // mostly short matrices; a few that run past the chain's capacity
            kind = $urandom_range(0, 19);
            if (kind == 0)
                len = 1;
            else if (kind < 15)
                len = $urandom_range(1, 12);
            else if (kind < 18)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(62, 72);
            burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++)
            begin
                if (kind == 0)
                    c = 4'($urandom_range(0, 15));
                else if (kind >= 18 || $urandom_range(0, 3) != 0)
                    c = drive_col;
                else
                    c = 4'($urandom_range(0, 15));
                drive_word(rand_sample(), c, k == len - 1,
                           burst ? 0 : $urandom_range(0, STALL_MAX), 1'b0, '0);
                words_sent++;
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cmed_pkg.sv
hw/rtl/cmed_cell.sv
hw/rtl/column_median.sv
bench/column_median_tb.sv
